// ----- hw/rtl/servo_command_frame_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the servo command frame decoder
// Clocked implication checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_FRAME_DECODER_ASSERT_SVH
`define SERVO_COMMAND_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SCFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/scfd_pkg.sv -----
// ----------------------------------------------------------------------------
// scfd_pkg
// Types and constants of the servo command frame decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int HEAD_DEPTH = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_CENTRE  = 4'd0,
        REG_THUMB_INDEX   = 4'd1,
        REG_OTHER_FINGER  = 4'd2,
        REG_ARM_OFFSET    = 4'd3
    } cfg_reg_t;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_R       = 8'h52;

    localparam logic [2:0] ARM_CHANNEL = 3'd5;

    localparam logic [7:0] CENTRE_RST       = 8'd130;
    localparam logic [9:0] THUMB_INDEX_RST  = 10'd170;
    localparam logic [9:0] OTHER_FINGER_RST = 10'd150;
    localparam logic [9:0] ARM_OFFSET_RST   = 10'd170;

    typedef struct packed {
        logic [7:0] angle_centre;
        logic [9:0] thumb_index_offset;
        logic [9:0] other_finger_offset;
        logic [9:0] arm_offset;
    } cfg_t;

    typedef struct packed {
        logic enable_n;
        logic dir;
        logic led;
    } levels_t;

    typedef struct packed {
        logic        frame_done;
        logic        servo_update;
        logic [2:0]  servo_channel;
        logic [11:0] servo_compare;
        logic        servo_reset;
        logic        home_request;
        logic        frame_error;
    } result_t;

    typedef logic [7:0] head_t [HEAD_DEPTH];

endpackage

// ----- hw/rtl/scfd_decode.sv -----
// ----------------------------------------------------------------------------
// scfd_decode
// Frame gathering and command decode for one received byte.
// ----------------------------------------------------------------------------
module scfd_decode
    import scfd_pkg::*;
#(
    parameter int FRAME_BYTES = 10,
    localparam int CNT_W      = $clog2(FRAME_BYTES)
)
(
    input  logic [7:0]       rx_byte,
    input  logic [CNT_W-1:0] byte_count,
    input  head_t            head,
    input  cfg_t             cfg,
    input  levels_t          levels,
    output head_t            head_next,
    output logic [CNT_W-1:0] byte_count_next,
    output levels_t          levels_next,
    output result_t          result
);

    head_t       head_eff;
    logic [7:0]  cmd;
    logic        close;
    logic        digits_ok;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;
    logic [9:0]  angle;
    logic [2:0]  chan;
    logic [9:0]  finger_off;
    logic [9:0]  centre_w;
    logic [9:0]  diff;

    // Merge the current byte into the head so a closing byte is decoded too.
    always_comb
    begin
        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            head_eff[i] = (byte_count == CNT_W'(i)) ? rx_byte : head[i];
        end
    end

    assign head_next = head_eff;
    assign cmd       = head_eff[0];
    assign close     = (rx_byte == CH_SLASH) || (byte_count >= CNT_W'(FRAME_BYTES - 1));
    assign byte_count_next = close ? '0 : byte_count + CNT_W'(1);

    assign digits_ok = (head_eff[1] >= CH_ZERO) && (head_eff[1] <= CH_NINE)
                    && (head_eff[2] >= CH_ZERO) && (head_eff[2] <= CH_NINE)
                    && (head_eff[3] >= CH_ZERO) && (head_eff[3] <= CH_NINE);

    assign d1 = 4'(head_eff[1] - CH_ZERO);
    assign d2 = 4'(head_eff[2] - CH_ZERO);
    assign d3 = 4'(head_eff[3] - CH_ZERO);
    assign angle = 10'(d1) * 10'd100 + 10'(d2) * 10'd10 + 10'(d3);

    assign chan       = 3'(cmd - CH_A);
    assign finger_off = (chan < 3'd2) ? cfg.thumb_index_offset : cfg.other_finger_offset;
    assign centre_w   = {2'b00, cfg.angle_centre};
    assign diff       = centre_w - angle;

    always_comb
    begin
        result      = '0;
        levels_next = levels;
        if (close)
        begin
            result.frame_done = 1'b1;
            if ((cmd >= CH_A) && (cmd <= CH_F))
            begin
                if (!digits_ok)
                begin
                    result.frame_error = 1'b1;
                end
                else if (chan == ARM_CHANNEL)
                begin
                    result.servo_update  = 1'b1;
                    result.servo_channel = ARM_CHANNEL;
                    result.servo_compare = {1'b0, angle, 1'b0} + 12'(cfg.arm_offset);
                end
                else if (angle > centre_w)
                begin
                    result.frame_error = 1'b1;
                end
                else
                begin
                    result.servo_update  = 1'b1;
                    result.servo_channel = chan;
                    result.servo_compare = {1'b0, diff, 1'b0} + 12'(finger_off);
                end
            end
            else if (cmd == CH_L)
            begin
                levels_next = '{enable_n: 1'b0, dir: 1'b1, led: 1'b0};
            end
            else if (cmd == CH_S)
            begin
                levels_next.led      = 1'b1;
                levels_next.enable_n = 1'b1;
            end
            else if (cmd == CH_R)
            begin
                levels_next.enable_n = 1'b0;
                levels_next.dir      = 1'b0;
            end
            else if (cmd == CH_K)
            begin
                result.servo_reset   = 1'b1;
                result.home_request  = 1'b1;
                levels_next.enable_n = 1'b1;
                levels_next.dir      = 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/servo_command_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// servo_command_frame_decoder
// Gathers received bytes into command frames and decodes servo and stepper
// commands, one result transfer per received byte.
//
// Channel  Direction  Signals                        Content
// s_*      in         s_tvalid s_tready s_tdata      received byte
// m_*      out        m_tvalid m_tready m_tdata      decoded result, tlast = frame_done
// cfg_*    in         cfg_valid cfg_ready            register index and write data
//
// One byte per cycle sustained while m_tready is high; each byte passes through the
// input register, the single decode stage and the result register.
// rst_n clears all valid flags and the byte count, sets all levels high and loads the cfg reset values.
// A stalled result register holds; the input register still takes one byte.
// cfg_ready is always high; writes are applied on the next edge.
// ----------------------------------------------------------------------------
module servo_command_frame_decoder
    import scfd_pkg::*;
#(
    parameter int FRAME_BYTES = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // [0] servo_update, [3:1] servo_channel,
                                               // [15:4] servo_compare, [16] servo_reset,
                                               // [17] home_request, [18] step_enable_n,
                                               // [19] step_dir, [20] led_level,
                                               // [21] frame_error, [23:22] zero
    output logic                  m_tlast,     // frame_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    result_t          out_result_reg;
    levels_t          out_levels_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    head_t            head_reg;
    head_t            head_next;
    levels_t          levels_reg;
    levels_t          levels_next;
    cfg_t             cfg_reg;
    result_t          result_next;
    logic             advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    scfd_decode #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_decode (
        .rx_byte         (in_byte_reg),
        .byte_count      (byte_count_reg),
        .head            (head_reg),
        .cfg             (cfg_reg),
        .levels          (levels_reg),
        .head_next       (head_next),
        .byte_count_next (byte_count_next),
        .levels_next     (levels_next),
        .result          (result_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Frame state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            byte_count_reg <= '0;
            levels_reg     <= '{enable_n: 1'b1, dir: 1'b1, led: 1'b1};
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                byte_count_reg <= byte_count_next;
                levels_reg     <= levels_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_reg       <= head_next;
            out_result_reg <= result_next;
            out_levels_reg <= levels_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{angle_centre:        CENTRE_RST,
                         thumb_index_offset:  THUMB_INDEX_RST,
                         other_finger_offset: OTHER_FINGER_RST,
                         arm_offset:          ARM_OFFSET_RST};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ANGLE_CENTRE: cfg_reg.angle_centre        <= cfg_data[7:0];
                REG_THUMB_INDEX:  cfg_reg.thumb_index_offset  <= cfg_data;
                REG_OTHER_FINGER: cfg_reg.other_finger_offset <= cfg_data;
                REG_ARM_OFFSET:   cfg_reg.arm_offset          <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_result_reg.frame_done;
    assign m_tdata  = {2'b00,
                       out_result_reg.frame_error,
                       out_levels_reg.led,
                       out_levels_reg.dir,
                       out_levels_reg.enable_n,
                       out_result_reg.home_request,
                       out_result_reg.servo_reset,
                       out_result_reg.servo_compare,
                       out_result_reg.servo_channel,
                       out_result_reg.servo_update};

`include "servo_command_frame_decoder_assert.svh"

    `SCFD_ASSERT_IMPL(a_flags_need_frame_end, clk, rst_n,
        out_valid_reg && !out_result_reg.frame_done,
        !out_result_reg.servo_update && !out_result_reg.servo_reset && !out_result_reg.frame_error,
        "command flags set on a byte that did not close a frame")
    `SCFD_ASSERT_IMPL(a_update_excludes_error, clk, rst_n,
        out_valid_reg && out_result_reg.servo_update,
        !out_result_reg.frame_error && (out_result_reg.servo_channel <= ARM_CHANNEL),
        "servo update with error or bad channel")
    `SCFD_ASSERT_IMPL(a_count_in_range, clk, rst_n,
        1'b1,
        byte_count_reg <= CNT_W'(FRAME_BYTES - 1),
        "byte count beyond frame length")
    `SCFD_ASSERT_NEXT(a_count_clears_on_close, clk, rst_n,
        advance && result_next.frame_done,
        byte_count_reg == '0,
        "byte count not cleared after frame end")

endmodule
